@@ hdl/rvbd_pkg.sv @@
// rvbd_pkg: result kinds, operation ids and operand format ids for the decoder
// no dependencies
package rvbd_pkg;

  localparam logic [1:0] KIND_OP   = 2'd0;
  localparam logic [1:0] KIND_ILL  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       comp;
    logic [7:0] op;
    logic [5:0] outer;
    logic [5:0] inner;
    logic [3:0] nbytes;
    logic       amo;
  } dec_res_t;

  // operation ids, dense in this order
  typedef enum logic [7:0] {
    OP_LDS, OP_LD, OP_FP_LD, OP_ST, OP_FP_ST,
    OP_FADD, OP_FSUB, OP_FMUL, OP_FDIV, OP_FSGNJ, OP_FMINMAX, OP_FCVT_FF, OP_FSQRT,
    OP_FCMP, OP_FCVT_FG, OP_FCVT_GF, OP_FMV_FG, OP_FMV_GF,
    OP_ADDI, OP_SLTI, OP_SLTUI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SHFLI, OP_SLOI,
    OP_SBSETI, OP_SBCLRI, OP_SBINVI,
    OP_CLZ, OP_CTZ, OP_PCNT, OP_BMATFLIP, OP_SEXT_B, OP_SEXT_H,
    OP_CRC32_B, OP_CRC32_H, OP_CRC32_W, OP_CRC32_D,
    OP_CRC32C_B, OP_CRC32C_H, OP_CRC32C_W, OP_CRC32C_D,
    OP_FSRI, OP_SRLI, OP_UNSHFLI, OP_SROI, OP_GORCI, OP_SRAI, OP_SBEXTI, OP_RORI, OP_GREVI,
    OP_ADDIW, OP_ADDIWU, OP_SLLIW, OP_SLLIUW, OP_SLOIW, OP_SBSETIW, OP_SBCLRIW, OP_SBINVIW,
    OP_CLZW, OP_CTZW, OP_PCNTW,
    OP_SRLIW, OP_SROIW, OP_GORCIW, OP_SRAIW, OP_SBEXTIW, OP_RORIW, OP_GREVIW,
    OP_FSL, OP_FSR, OP_CMIX, OP_CMOV,
    OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND,
    OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_SUB, OP_SRA,
    OP_SHFL, OP_BMATOR, OP_PACK, OP_UNSHFL, OP_BEXT, OP_PACKH, OP_CLMUL, OP_CLMULR,
    OP_CLMULH, OP_MIN, OP_MAX, OP_MINU, OP_MAXU,
    OP_SLO, OP_SH1ADD, OP_SH2ADD, OP_SRO, OP_SH3ADD, OP_SBSET, OP_GORC, OP_ROL, OP_ROR,
    OP_SBINV, OP_GREV,
    OP_XNOR, OP_ORN, OP_ANDN, OP_SBCLR, OP_BMATXOR, OP_PACKU, OP_SBEXT, OP_BDEP, OP_BFP,
    OP_ADDW, OP_SLLW, OP_SRLW, OP_MULW, OP_DIVW, OP_DIVUW, OP_REMW, OP_REMUW, OP_SUBW,
    OP_SRAW,
    OP_ADDUW, OP_SHFLW, OP_PACKW, OP_UNSHFLW, OP_BEXTW, OP_ADDWU, OP_CLMULW, OP_CLMULRW,
    OP_CLMULHW,
    OP_SLOW, OP_SH1ADDUW, OP_SH2ADDUW, OP_SROW, OP_SH3ADDUW, OP_SBSETW, OP_GORCW, OP_ROLW,
    OP_RORW, OP_SBINVW, OP_GREVW,
    OP_SUBUW, OP_SBCLRW, OP_PACKUW, OP_SBEXTW, OP_BDEPW, OP_BFPW, OP_SUBWU,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_PRIV, OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI,
    OP_AMOADD, OP_AMOSWAP, OP_LR, OP_SC, OP_AMOXOR, OP_AMOAND, OP_AMOOR, OP_AMOMIN,
    OP_AMOMAX, OP_AMOMINU, OP_AMOMAXU,
    OP_JALR, OP_LUI, OP_FENCE, OP_AUIPC, OP_FMADD, OP_FMSUB, OP_FNMSUB, OP_FNMADD,
    OP_TRAP, OP_JAL
  } op_num_t;

  localparam logic [7:0] OP_ILLEGAL = 8'hff;

  // operand format ids
  localparam logic [5:0] FMT_NONE = 6'd0, FMT_FPR_TO_GPR = 6'd1, FMT_GPR_TO_FPR = 6'd2;
  localparam logic [5:0] FMT_CSR = 6'd3, FMT_CSRI = 6'd4, FMT_C_JR = 6'd5, FMT_C_MOV = 6'd6;
  localparam logic [5:0] FMT_C_JALR = 6'd7, FMT_C_ADD = 6'd8, FMT_C_ADDI16SP = 6'd9;
  localparam logic [5:0] FMT_CI_SIMM_LUI = 6'd10, FMT_CS = 6'd11, FMT_CB_SHIFT = 6'd12;
  localparam logic [5:0] FMT_CB_ANDI = 6'd13, FMT_I = 6'd14, FMT_F_I = 6'd15, FMT_U = 6'd16;
  localparam logic [5:0] FMT_S = 6'd17, FMT_F_S = 6'd18, FMT_R = 6'd19, FMT_F_R = 6'd20;
  localparam logic [5:0] FMT_B = 6'd21, FMT_J = 6'd22, FMT_C_ADDI4SPN = 6'd23;
  localparam logic [5:0] FMT_C_FLD = 6'd24, FMT_C_LW = 6'd25, FMT_C_LD = 6'd26;
  localparam logic [5:0] FMT_C_FSD = 6'd27, FMT_C_SW = 6'd28, FMT_C_SD = 6'd29;
  localparam logic [5:0] FMT_CI_SIMM = 6'd30, FMT_C_LI = 6'd31, FMT_C_J = 6'd32;
  localparam logic [5:0] FMT_CB = 6'd33, FMT_CI_UIMM = 6'd34, FMT_C_FLDSP = 6'd35;
  localparam logic [5:0] FMT_C_LWSP = 6'd36, FMT_C_LDSP = 6'd37, FMT_C_FSDSP = 6'd38;
  localparam logic [5:0] FMT_C_SWSP = 6'd39, FMT_C_SDSP = 6'd40;

  // register-register ops, key is {funct7, funct3}; OP_ILLEGAL when unlisted
  function automatic logic [7:0] pair64(input logic [9:0] k);
    logic [7:0] r;
    unique case (k)
      {7'd0, 3'd0}: r = OP_ADD;    {7'd0, 3'd1}: r = OP_SLL;
      {7'd0, 3'd2}: r = OP_SLT;    {7'd0, 3'd3}: r = OP_SLTU;
      {7'd0, 3'd4}: r = OP_XOR;    {7'd0, 3'd5}: r = OP_SRL;
      {7'd0, 3'd6}: r = OP_OR;     {7'd0, 3'd7}: r = OP_AND;
      {7'd1, 3'd0}: r = OP_MUL;    {7'd1, 3'd1}: r = OP_MULH;
      {7'd1, 3'd2}: r = OP_MULHSU; {7'd1, 3'd3}: r = OP_MULHU;
      {7'd1, 3'd4}: r = OP_DIV;    {7'd1, 3'd5}: r = OP_DIVU;
      {7'd1, 3'd6}: r = OP_REM;    {7'd1, 3'd7}: r = OP_REMU;
      {7'd32, 3'd0}: r = OP_SUB;   {7'd32, 3'd5}: r = OP_SRA;
      {7'd4, 3'd1}: r = OP_SHFL;   {7'd4, 3'd3}: r = OP_BMATOR;
      {7'd4, 3'd4}: r = OP_PACK;   {7'd4, 3'd5}: r = OP_UNSHFL;
      {7'd4, 3'd6}: r = OP_BEXT;   {7'd4, 3'd7}: r = OP_PACKH;
      {7'd5, 3'd1}: r = OP_CLMUL;  {7'd5, 3'd2}: r = OP_CLMULR;
      {7'd5, 3'd3}: r = OP_CLMULH; {7'd5, 3'd4}: r = OP_MIN;
      {7'd5, 3'd6}: r = OP_MAX;    {7'd5, 3'd5}: r = OP_MINU;
      {7'd5, 3'd7}: r = OP_MAXU;
      {7'd16, 3'd1}: r = OP_SLO;   {7'd16, 3'd2}: r = OP_SH1ADD;
      {7'd16, 3'd4}: r = OP_SH2ADD; {7'd16, 3'd5}: r = OP_SRO;
      {7'd16, 3'd6}: r = OP_SH3ADD; {7'd20, 3'd1}: r = OP_SBSET;
      {7'd20, 3'd5}: r = OP_GORC;  {7'd48, 3'd1}: r = OP_ROL;
      {7'd48, 3'd5}: r = OP_ROR;   {7'd52, 3'd1}: r = OP_SBINV;
      {7'd52, 3'd5}: r = OP_GREV;
      {7'd32, 3'd4}: r = OP_XNOR;  {7'd32, 3'd6}: r = OP_ORN;
      {7'd32, 3'd7}: r = OP_ANDN;
      {7'd36, 3'd1}: r = OP_SBCLR; {7'd36, 3'd3}: r = OP_BMATXOR;
      {7'd36, 3'd4}: r = OP_PACKU; {7'd36, 3'd5}: r = OP_SBEXT;
      {7'd36, 3'd6}: r = OP_BDEP;  {7'd36, 3'd7}: r = OP_BFP;
      default: r = OP_ILLEGAL;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pair32(input logic [9:0] k);
    logic [7:0] r;
    unique case (k)
      {7'd0, 3'd0}: r = OP_ADDW;   {7'd0, 3'd1}: r = OP_SLLW;
      {7'd0, 3'd5}: r = OP_SRLW;   {7'd1, 3'd0}: r = OP_MULW;
      {7'd1, 3'd4}: r = OP_DIVW;   {7'd1, 3'd5}: r = OP_DIVUW;
      {7'd1, 3'd6}: r = OP_REMW;   {7'd1, 3'd7}: r = OP_REMUW;
      {7'd32, 3'd0}: r = OP_SUBW;  {7'd32, 3'd5}: r = OP_SRAW;
      {7'd4, 3'd0}: r = OP_ADDUW;  {7'd4, 3'd1}: r = OP_SHFLW;
      {7'd4, 3'd4}: r = OP_PACKW;  {7'd4, 3'd5}: r = OP_UNSHFLW;
      {7'd4, 3'd6}: r = OP_BEXTW;  {7'd5, 3'd0}: r = OP_ADDWU;
      {7'd5, 3'd1}: r = OP_CLMULW; {7'd5, 3'd2}: r = OP_CLMULRW;
      {7'd5, 3'd3}: r = OP_CLMULHW;
      {7'd16, 3'd1}: r = OP_SLOW;  {7'd16, 3'd2}: r = OP_SH1ADDUW;
      {7'd16, 3'd4}: r = OP_SH2ADDUW; {7'd16, 3'd5}: r = OP_SROW;
      {7'd16, 3'd6}: r = OP_SH3ADDUW; {7'd20, 3'd1}: r = OP_SBSETW;
      {7'd20, 3'd5}: r = OP_GORCW; {7'd48, 3'd1}: r = OP_ROLW;
      {7'd48, 3'd5}: r = OP_RORW;  {7'd52, 3'd1}: r = OP_SBINVW;
      {7'd52, 3'd5}: r = OP_GREVW;
      {7'd36, 3'd0}: r = OP_SUBUW; {7'd36, 3'd1}: r = OP_SBCLRW;
      {7'd36, 3'd4}: r = OP_PACKUW; {7'd36, 3'd5}: r = OP_SBEXTW;
      {7'd36, 3'd6}: r = OP_BDEPW; {7'd36, 3'd7}: r = OP_BFPW;
      {7'd37, 3'd0}: r = OP_SUBWU;
      default: r = OP_ILLEGAL;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/rvbd_full_dec.sv @@
// rvbd_full_dec: combinational decode of a 32-bit instruction word
// depends on rvbd_pkg
module rvbd_full_dec (
  input  logic [31:0]             instr,
  output rvbd_pkg::dec_res_t      res
);
  import rvbd_pkg::*;

  logic [4:0] opc, key, low;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [7:0] pop;

  assign opc = instr[6:2];
  assign f3  = instr[14:12];
  assign key = instr[31:27];
  assign low = instr[24:20];
  assign f7  = instr[31:25];

  always_comb begin
    res = '0;
    res.kind = KIND_NONE;
    pop = OP_ILLEGAL;
    unique case (opc)
      5'o00: begin
        res.outer = FMT_I;
        if (f3 == 3'd7) begin
          res.kind = KIND_ILL;
        end else begin
          res.kind = KIND_OP;
          res.op = (f3 < 3'd3) ? OP_LDS : OP_LD;
          unique case (f3[1:0])
            2'd0: res.nbytes = 4'd1;
            2'd1: res.nbytes = 4'd2;
            2'd2: res.nbytes = 4'd4;
            default: res.nbytes = 4'd8;
          endcase
        end
      end
      5'o01, 5'o11: begin
        res.outer = opc[3] ? FMT_F_S : FMT_F_I;
        if (f3 == 3'd2 || f3 == 3'd3) begin
          res.kind = KIND_OP;
          res.op = opc[3] ? OP_FP_ST : OP_FP_LD;
          res.nbytes = f3[0] ? 4'd8 : 4'd4;
        end else begin
          res.kind = KIND_ILL;
        end
      end
      5'o03: begin res.kind = KIND_OP; res.op = OP_FENCE; end
      5'o04: begin
        res.outer = FMT_I;
        res.kind = KIND_OP;
        unique case (f3)
          3'd0: res.op = OP_ADDI;
          3'd2: res.op = OP_SLTI;
          3'd3: res.op = OP_SLTUI;
          3'd4: res.op = OP_XORI;
          3'd6: res.op = OP_ORI;
          3'd7: res.op = OP_ANDI;
          3'd1: begin
            unique case (key)
              5'd0: res.op = OP_SLLI;
              5'd1: res.op = OP_SHFLI;
              5'd4: res.op = OP_SLOI;
              5'd5: res.op = OP_SBSETI;
              5'd9: res.op = OP_SBCLRI;
              5'd13: res.op = OP_SBINVI;
              5'd12: begin
                if (low <= 5'd5) res.op = OP_CLZ + {3'd0, low};
                else if (low[4:2] == 3'b100) res.op = OP_CRC32_B + {6'd0, low[1:0]};
                else if (low[4:2] == 3'b110) res.op = OP_CRC32C_B + {6'd0, low[1:0]};
                else res.kind = KIND_ILL;
              end
              default: res.kind = KIND_ILL;
            endcase
          end
          default: begin
            if (instr[26]) begin
              res.op = OP_FSRI;
            end else begin
              unique case (key)
                5'd0: res.op = OP_SRLI;
                5'd1: res.op = OP_UNSHFLI;
                5'd4: res.op = OP_SROI;
                5'd5: res.op = OP_GORCI;
                5'd8: res.op = OP_SRAI;
                5'd9: res.op = OP_SBEXTI;
                5'd12: res.op = OP_RORI;
                5'd13: res.op = OP_GREVI;
                default: res.kind = KIND_ILL;
              endcase
            end
          end
        endcase
      end
      5'o05: begin res.outer = FMT_U; res.kind = KIND_OP; res.op = OP_AUIPC; end
      5'o06: begin
        res.outer = FMT_I;
        res.kind = KIND_OP;
        unique case (f3)
          3'd0: res.op = OP_ADDIW;
          3'd4: res.op = OP_ADDIWU;
          3'd1: begin
            unique case (key)
              5'd0: res.op = OP_SLLIW;
              5'd1: res.op = OP_SLLIUW;
              5'd4: res.op = OP_SLOIW;
              5'd5: res.op = OP_SBSETIW;
              5'd9: res.op = OP_SBCLRIW;
              5'd13: res.op = OP_SBINVIW;
              5'd12: begin
                if (low <= 5'd2) res.op = OP_CLZW + {3'd0, low};
                else res.kind = KIND_ILL;
              end
              default: res.kind = KIND_NONE;
            endcase
          end
          3'd5: begin
            if (instr[26]) begin
              res.op = OP_FSRI;
            end else begin
              unique case (key)
                5'd0: res.op = OP_SRLIW;
                5'd4: res.op = OP_SROIW;
                5'd5: res.op = OP_GORCIW;
                5'd8: res.op = OP_SRAIW;
                5'd9: res.op = OP_SBEXTIW;
                5'd12: res.op = OP_RORIW;
                5'd13: res.op = OP_GREVIW;
                default: res.kind = KIND_ILL;
              endcase
            end
          end
          default: res.kind = KIND_ILL;
        endcase
      end
      5'o10: begin
        res.outer = FMT_S;
        if (!f3[2]) begin
          res.kind = KIND_OP;
          res.op = OP_ST;
          res.nbytes = 4'd1 << f3[1:0];
        end
      end
      5'o13: begin
        res.outer = FMT_R;
        if (f3[2]) begin
          res.kind = KIND_ILL;
        end else begin
          res.nbytes = 4'd1 << f3[1:0];
          res.kind = KIND_OP;
          res.amo = (key != 5'd2);
          unique case (key)
            5'd0: res.op = OP_AMOADD;
            5'd1: res.op = OP_AMOSWAP;
            5'd2: res.op = OP_LR;
            5'd3: res.op = OP_SC;
            5'd4: res.op = OP_AMOXOR;
            5'h0c: res.op = OP_AMOAND;
            5'h08: res.op = OP_AMOOR;
            5'h10: res.op = OP_AMOMIN;
            5'h14: res.op = OP_AMOMAX;
            5'h18: res.op = OP_AMOMINU;
            5'h1c: res.op = OP_AMOMAXU;
            default: res.kind = KIND_NONE;
          endcase
        end
      end
      5'o14, 5'o16: begin
        res.outer = FMT_R;
        res.kind = KIND_OP;
        // funnel shifts, and cmix/cmov on the 64-bit side only
        if (f7[1:0] == 2'b10 || (!opc[1] && f7[1:0] == 2'b11)) begin
          if (f3 == 3'd1) res.op = f7[0] ? OP_CMIX : OP_FSL;
          else if (f3 == 3'd5) res.op = f7[0] ? OP_CMOV : OP_FSR;
          else res.kind = KIND_ILL;
        end else begin
          pop = opc[1] ? pair32({f7, f3}) : pair64({f7, f3});
          if (pop == OP_ILLEGAL) res.kind = KIND_ILL;
          else res.op = pop;
        end
      end
      5'o15: begin res.outer = FMT_U; res.kind = KIND_OP; res.op = OP_LUI; end
      5'o20, 5'o21, 5'o22, 5'o23: begin
        res.outer = FMT_F_R;
        res.kind = KIND_OP;
        res.op = OP_FMADD + {6'd0, opc[1:0]};
      end
      5'o24: begin
        res.outer = FMT_F_R;
        res.kind = KIND_OP;
        unique case (key)
          5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: res.op = OP_FADD + {3'd0, key};
          5'd8: res.op = OP_FCVT_FF;
          5'd11: res.op = OP_FSQRT;
          5'd20: begin res.inner = FMT_FPR_TO_GPR; res.op = OP_FCMP; end
          5'd24: begin res.inner = FMT_FPR_TO_GPR; res.op = OP_FCVT_FG; end
          5'd26: begin res.inner = FMT_GPR_TO_FPR; res.op = OP_FCVT_GF; end
          5'd28: begin res.inner = FMT_FPR_TO_GPR; res.op = OP_FMV_FG; end
          5'd30: begin res.inner = FMT_GPR_TO_FPR; res.op = OP_FMV_GF; end
          default: res.kind = KIND_ILL;
        endcase
      end
      5'o30: begin
        res.outer = FMT_B;
        if (f3[2]) begin
          res.kind = KIND_OP; res.op = OP_BLT + {6'd0, f3[1:0]};
        end else if (!f3[1]) begin
          res.kind = KIND_OP; res.op = OP_BEQ + {7'd0, f3[0]};
        end
      end
      5'o31: begin res.outer = FMT_I; res.kind = KIND_OP; res.op = OP_JALR; end
      5'o32: begin res.kind = KIND_OP; res.op = OP_TRAP; end
      5'o33: begin res.outer = FMT_J; res.kind = KIND_OP; res.op = OP_JAL; end
      5'o34: begin
        if (f3 == 3'd0) begin
          res.kind = KIND_OP; res.op = OP_PRIV;
        end else if (!f3[2]) begin
          res.kind = KIND_OP; res.inner = FMT_CSR;
          res.op = OP_CSRRW + {6'd0, f3[1:0] - 2'd1};
        end else if (f3 != 3'd4) begin
          res.kind = KIND_OP; res.inner = FMT_CSRI;
          res.op = OP_CSRRWI + {6'd0, f3[1:0] - 2'd1};
        end
      end
      default: res.kind = KIND_ILL;
    endcase
  end
endmodule

@@ hdl/rvbd_rvc_dec.sv @@
// rvbd_rvc_dec: combinational decode of a 16-bit compressed instruction
// depends on rvbd_pkg
module rvbd_rvc_dec (
  input  logic [15:0]             instr,
  output rvbd_pkg::dec_res_t      res
);
  import rvbd_pkg::*;

  logic [2:0] msel, s2;

  assign msel = {instr[12], instr[11:7] != 5'd0, instr[6:2] != 5'd0};
  assign s2   = {instr[12], instr[6:5]};

  always_comb begin
    res = '0;
    res.comp = 1'b1;
    res.kind = KIND_OP;
    unique case ({instr[1:0], instr[15:13]})
      5'o00: begin res.outer = FMT_C_ADDI4SPN; res.op = OP_ADDI; end
      5'o01: begin res.outer = FMT_C_FLD; res.op = OP_FP_LD; res.nbytes = 4'd8; end
      5'o02: begin res.outer = FMT_C_LW; res.op = OP_LDS; res.nbytes = 4'd4; end
      5'o03: begin res.outer = FMT_C_LD; res.op = OP_LD; res.nbytes = 4'd8; end
      5'o05: begin res.outer = FMT_C_FSD; res.op = OP_FP_ST; res.nbytes = 4'd8; end
      5'o06: begin res.outer = FMT_C_SW; res.op = OP_ST; res.nbytes = 4'd4; end
      5'o07: begin res.outer = FMT_C_SD; res.op = OP_ST; res.nbytes = 4'd8; end
      5'o10: begin res.outer = FMT_CI_SIMM; res.op = OP_ADDI; end
      5'o11: begin res.outer = FMT_CI_SIMM; res.op = OP_ADDIW; end
      5'o12: begin res.outer = FMT_C_LI; res.op = OP_ADDI; end
      5'o13: begin
        // rd zero is reserved here
        if (instr[11:7] == 5'd0) res.kind = KIND_ILL;
        else if (instr[11:7] == 5'd2) begin
          res.inner = FMT_C_ADDI16SP; res.op = OP_ADDI;
        end else begin
          res.inner = FMT_CI_SIMM_LUI; res.op = OP_LUI;
        end
      end
      5'o14: begin
        unique case (instr[11:10])
          2'd0: begin res.inner = FMT_CB_SHIFT; res.op = OP_SRLI; end
          2'd1: begin res.inner = FMT_CB_SHIFT; res.op = OP_SRAI; end
          2'd2: begin res.inner = FMT_CB_ANDI; res.op = OP_ANDI; end
          default: begin
            res.inner = FMT_CS;
            unique case (s2)
              3'd0: res.op = OP_SUB;
              3'd1: res.op = OP_XOR;
              3'd2: res.op = OP_OR;
              3'd3: res.op = OP_AND;
              3'd4: res.op = OP_SUBW;
              3'd5: res.op = OP_ADDW;
              default: begin res.kind = KIND_NONE; res.inner = FMT_NONE; end
            endcase
          end
        endcase
      end
      5'o15: begin res.outer = FMT_C_J; res.op = OP_JAL; end
      5'o16: begin res.outer = FMT_CB; res.op = OP_BEQ; end
      5'o17: begin res.outer = FMT_CB; res.op = OP_BNE; end
      5'o20: begin res.outer = FMT_CI_UIMM; res.op = OP_SLLI; end
      5'o21: begin res.outer = FMT_C_FLDSP; res.op = OP_FP_LD; res.nbytes = 4'd8; end
      5'o22: begin res.outer = FMT_C_LWSP; res.op = OP_LDS; res.nbytes = 4'd4; end
      5'o23: begin res.outer = FMT_C_LDSP; res.op = OP_LD; res.nbytes = 4'd8; end
      5'o24: begin
        unique case (msel)
          3'd2: begin res.inner = FMT_C_JR; res.op = OP_JALR; end
          3'd3: begin res.inner = FMT_C_MOV; res.op = OP_ADD; end
          3'd6: begin res.inner = FMT_C_JALR; res.op = OP_JALR; end
          3'd7: begin res.inner = FMT_C_ADD; res.op = OP_ADD; end
          default: res.kind = KIND_ILL;
        endcase
      end
      5'o25: begin res.outer = FMT_C_FSDSP; res.op = OP_FP_ST; res.nbytes = 4'd8; end
      5'o26: begin res.outer = FMT_C_SWSP; res.op = OP_ST; res.nbytes = 4'd4; end
      5'o27: begin res.outer = FMT_C_SDSP; res.op = OP_ST; res.nbytes = 4'd8; end
      default: res.kind = KIND_ILL;
    endcase
  end
endmodule

@@ hdl/rv64gc_bitmanip_instruction_decoder.sv @@
// rv64gc_bitmanip_instruction_decoder: top level, input register, decode, result register
// depends on rvbd_pkg, rvbd_full_dec, rvbd_rvc_dec
//
// channel   dir  handshake            payload
// in_       in   in_valid/in_ready    in_instr_word
// out_      out  out_valid/out_ready  out_result_kind .. out_amo_store
//
// one transaction a cycle while out_ready holds; input register, then result register
// rate set by the single decode pass between the two registers
// rst_n (synchronous) empties both stages
// a stalled result holds its stage; the input stage stays ready while the decode stage can move
module rv64gc_bitmanip_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic        out_is_compressed,
  output logic [7:0]  out_op_number,
  output logic [5:0]  out_outer_format,
  output logic [5:0]  out_inner_format,
  output logic [3:0]  out_access_bytes,
  output logic        out_amo_store
);
  import rvbd_pkg::*;

  logic        ivld_r, ovld_r;
  logic [31:0] iw_r;
  dec_res_t    full_res, rvc_res, dec_nxt, res_r;
  logic        adv, take;

  rvbd_full_dec u_full (.instr(iw_r), .res(full_res));
  rvbd_rvc_dec  u_rvc  (.instr(iw_r[15:0]), .res(rvc_res));

  always_comb begin
    dec_nxt = (iw_r[1:0] != 2'b11) ? rvc_res : full_res;
    if (dec_nxt.kind != KIND_OP) begin
      dec_nxt.op  = '0;
      dec_nxt.amo = 1'b0;
    end
  end

  assign adv      = !ovld_r || out_ready;
  assign in_ready = !ivld_r || adv;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (in_ready) ivld_r <= in_valid;
      if (adv) ovld_r <= ivld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) iw_r <= in_instr_word;
    if (adv && ivld_r) res_r <= dec_nxt;
  end

  assign out_valid         = ovld_r;
  assign out_result_kind   = res_r.kind;
  assign out_is_compressed = res_r.comp;
  assign out_op_number     = res_r.op;
  assign out_outer_format  = res_r.outer;
  assign out_inner_format  = res_r.inner;
  assign out_access_bytes  = res_r.nbytes;
  assign out_amo_store     = res_r.amo;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("result changed while stalled");
  a_amo_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_amo_store |-> out_result_kind == KIND_OP)
    else $error("amo flag on a non-operation");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    ivld_r && adv |=> out_valid)
    else $error("decoded transaction lost");
endmodule
